// ===== rtl/vsb_pkg.sv =====
// shared constants, types and helpers for the vertex skinning blend block
package vsb_pkg;

  // palette geometry
  localparam int MAX_JOINTS      = 64;
  localparam int MAX_INFLUENCES  = 4;
  localparam int COLS            = 3;
  localparam int ROWS            = 4;
  localparam int WORDS_PER_JOINT = ROWS * COLS;
  localparam int ROW_TRANS       = ROWS - 1;
  localparam int PAL_DEPTH       = MAX_JOINTS * WORDS_PER_JOINT;
  localparam int PAL_AW          = $clog2(PAL_DEPTH);
  localparam int WORD_W          = $clog2(WORDS_PER_JOINT);
  localparam int INF_CNT_W       = $clog2(MAX_INFLUENCES + 1);

  // item field widths
  localparam int JOINT_W  = 7;
  localparam int COORD_W  = 32;
  localparam int WEIGHT_W = 16;

  localparam logic [JOINT_W-1:0] JOINT_UNUSED = '1;

  // datapath widths
  localparam int MUL_W  = COORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 48;
  localparam int T_W    = ACC_W + 2;
  localparam int WP_W   = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // sequencer schedule: the coordinate schedules are staggered and overlapped
  localparam int COORDS       = 3;
  localparam int ACC_IDX_W    = $clog2(COORDS);
  localparam int COORD_PERIOD = 7;
  localparam int COORD_PHASES = 11;
  localparam int STEP_LAST    = (COORDS - 1) * COORD_PERIOD + COORD_PHASES - 1;
  localparam int STEP_W       = $clog2(STEP_LAST + 1);

  // operand choice of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_V0,
    MUL_V1,
    MUL_V2,
    MUL_TH,
    MUL_TL
  } mul_sel_e;

  // per-step datapath controls from the sequencer
  typedef struct packed {
    logic [WORD_W-1:0]    rd_idx;
    logic                 t_init;
    logic                 t_add;
    mul_sel_e             mul_sel;
    logic                 t_clamp;
    logic                 wph_ld;
    logic                 wp_ld;
    logic                 acc_ld;
    logic [ACC_IDX_W-1:0] acc_idx;
  } seq_ctrl_t;

  // sequencer status
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  // palette word address of a joint and a matrix word
  function automatic logic [PAL_AW-1:0] pal_addr(logic [JOINT_W-2:0] j,
                                                 logic [WORD_W-1:0] e);
    return PAL_AW'(int'(j) * WORDS_PER_JOINT + int'(e));
  endfunction

endpackage

// ===== rtl/vsb_ram.sv =====
// generic simple dual port ram with one write port and a registered read port
module vsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vsb_mul.sv =====
// shared signed multiplier with a registered product
module vsb_mul (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [vsb_pkg::MUL_W-1:0] a_i,
  input  logic signed [vsb_pkg::MUL_W-1:0] b_i,
  output logic signed [vsb_pkg::PROD_W-1:0] prod_o
);

  logic signed [vsb_pkg::PROD_W-1:0] prod_q;

  // one product per enabled cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/vsb_seq.sv =====
// step sequencer that schedules palette reads and multiplier use per influence
module vsb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output vsb_pkg::seq_ctrl_t  ctrl_o,
  output vsb_pkg::seq_stat_t  stat_o
);

  // phases of one coordinate, relative to its first step
  localparam int PH_RD_TRANS = 0;
  localparam int PH_RD_R0    = 1;
  localparam int PH_MUL_V0   = 2;
  localparam int PH_MUL_V1   = 3;
  localparam int PH_MUL_V2   = 4;
  localparam int PH_ADD_LAST = 5;
  localparam int PH_CLAMP    = 6;
  localparam int PH_MUL_TH   = 7;
  localparam int PH_MUL_TL   = 8;
  localparam int PH_WP       = 9;
  localparam int PH_ACC      = 10;

  logic                       busy_q;
  logic [vsb_pkg::STEP_W-1:0] step_q;
  logic                       last_step;
  vsb_pkg::seq_ctrl_t         ctrl;

  assign last_step = (step_q == vsb_pkg::STEP_W'(vsb_pkg::STEP_LAST));

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (last_step) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // decode the overlapped coordinate schedules
  always_comb begin
    int ph;
    ctrl = '0;
    ph   = 0;
    if (busy_q) begin
      for (int c = 0; c < vsb_pkg::COORDS; c++) begin
        ph = int'(step_q) - c * vsb_pkg::COORD_PERIOD;
        unique case (ph)
          PH_RD_TRANS: begin
            ctrl.rd_idx = vsb_pkg::WORD_W'(vsb_pkg::ROW_TRANS * vsb_pkg::COLS + c);
          end
          PH_RD_R0: begin
            ctrl.rd_idx = vsb_pkg::WORD_W'(c);
            ctrl.t_init = 1'b1;
          end
          PH_MUL_V0: begin
            ctrl.rd_idx  = vsb_pkg::WORD_W'(vsb_pkg::COLS + c);
            ctrl.mul_sel = vsb_pkg::MUL_V0;
          end
          PH_MUL_V1: begin
            ctrl.rd_idx  = vsb_pkg::WORD_W'(2 * vsb_pkg::COLS + c);
            ctrl.mul_sel = vsb_pkg::MUL_V1;
            ctrl.t_add   = 1'b1;
          end
          PH_MUL_V2: begin
            ctrl.mul_sel = vsb_pkg::MUL_V2;
            ctrl.t_add   = 1'b1;
          end
          PH_ADD_LAST: begin
            ctrl.t_add = 1'b1;
          end
          PH_CLAMP: begin
            ctrl.t_clamp = 1'b1;
          end
          PH_MUL_TH: begin
            ctrl.mul_sel = vsb_pkg::MUL_TH;
          end
          PH_MUL_TL: begin
            ctrl.mul_sel = vsb_pkg::MUL_TL;
            ctrl.wph_ld  = 1'b1;
          end
          PH_WP: begin
            ctrl.wp_ld = 1'b1;
          end
          PH_ACC: begin
            ctrl.acc_ld  = 1'b1;
            ctrl.acc_idx = vsb_pkg::ACC_IDX_W'(c);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign ctrl_o      = ctrl;
  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && last_step;

endmodule

// ===== rtl/vertex_skinning_blend.sv =====
// linear blend skinning: 3x4 joint palette, shared multiplier, weighted accumulation
// throughput: a counted influence holds the input off while the sequencer runs, which issues
//   15 products on the shared 33x33 multiplier; a palette load, or an influence that does not
//   count and is not last, leaves the input ready for the next transfer
// output: a last influence moves to the output state after its sequencing ends (or its
//   transfer) and loads the output register there once the output register is free
// reset clears accumulators, count and output valid; palette undefined until loaded, no clear
module vertex_skinning_blend (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: joint[6:0], element[10:7], value[42:11], weight[58:43],
  //        vert_x[90:59], vert_y[122:91], vert_z[154:123], zero fill[159:155]
  input  logic [159:0] s_axis_tdata,
  // tuser: op[0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  m_axis_tdata,
  // tuser: saturated[0]
  output logic         m_axis_tuser
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_OUT
  } state_e;

  localparam int AW  = vsb_pkg::PAL_AW;
  localparam int CW  = vsb_pkg::COORD_W;
  localparam int JW  = vsb_pkg::JOINT_W;
  localparam int WW  = vsb_pkg::WORD_W;
  localparam int ACW = vsb_pkg::ACC_W;
  localparam int TW  = vsb_pkg::T_W;

  // input fields
  logic [JW-1:0]                 in_joint;
  logic [WW-1:0]                 in_element;
  logic [CW-1:0]                 in_value;
  logic [vsb_pkg::WEIGHT_W-1:0]  in_weight;
  logic [CW-1:0]                 in_vx, in_vy, in_vz;

  assign in_joint   = s_axis_tdata[6:0];
  assign in_element = s_axis_tdata[10:7];
  assign in_value   = s_axis_tdata[42:11];
  assign in_weight  = s_axis_tdata[58:43];
  assign in_vx      = s_axis_tdata[90:59];
  assign in_vy      = s_axis_tdata[122:91];
  assign in_vz      = s_axis_tdata[154:123];

  state_e                          state_q;
  logic                            m_valid_q;
  logic [CW-1:0]                   ox_q, oy_q, oz_q;
  logic                            osat_q;

  logic                            first_pending_q;
  logic [vsb_pkg::INF_CNT_W-1:0]   inf_cnt_q;
  logic                            sat_q;
  logic signed [ACW-1:0]           acc_q [vsb_pkg::COORDS];

  logic [AW-1:0]                   base_q;
  logic [vsb_pkg::WEIGHT_W-1:0]    w_q;
  logic [CW-1:0]                   vx_q, vy_q, vz_q;
  logic                            last_q;

  logic signed [TW-1:0]            t_q;
  logic signed [ACW-1:0]           tc_q;
  logic signed [ACW-1:0]           wph_q;
  logic signed [vsb_pkg::WP_W-1:0] wp_q;

  // transfer decode
  logic in_xfer, is_infl, joint_ok, cnt_ok, takes, counted, pal_we, out_free, out_load;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign is_infl  = in_xfer && s_axis_tuser;
  assign joint_ok = !in_joint[JW-1] && (int'(in_joint[JW-2:0]) < vsb_pkg::MAX_JOINTS);
  assign cnt_ok   = (int'(inf_cnt_q) < vsb_pkg::MAX_INFLUENCES);
  assign takes    = first_pending_q ||
                    ((in_weight != '0) && (in_joint != vsb_pkg::JOINT_UNUSED));
  assign counted  = is_infl && cnt_ok && takes && joint_ok;
  assign pal_we   = in_xfer && !s_axis_tuser && joint_ok &&
                    (int'(in_element) < vsb_pkg::WORDS_PER_JOINT);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_OUT) && out_free;

  // sequencer
  vsb_pkg::seq_ctrl_t ctrl;
  vsb_pkg::seq_stat_t seq_stat;

  vsb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (counted),
    .ctrl_o  (ctrl),
    .stat_o  (seq_stat)
  );

  // joint palette
  logic [CW-1:0] rdata;
  logic [AW-1:0] raddr;

  assign raddr = base_q + AW'(ctrl.rd_idx);

  vsb_ram #(
    .WIDTH (CW),
    .DEPTH (vsb_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (vsb_pkg::pal_addr(in_joint[JW-2:0], in_element)),
    .wdata_i (in_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared multiplier operand select
  logic signed [vsb_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [vsb_pkg::PROD_W-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      vsb_pkg::MUL_V0: begin
        mul_a = {vx_q[CW-1], vx_q};
        mul_b = {rdata[CW-1], rdata};
      end
      vsb_pkg::MUL_V1: begin
        mul_a = {vy_q[CW-1], vy_q};
        mul_b = {rdata[CW-1], rdata};
      end
      vsb_pkg::MUL_V2: begin
        mul_a = {vz_q[CW-1], vz_q};
        mul_b = {rdata[CW-1], rdata};
      end
      vsb_pkg::MUL_TH: begin
        mul_a = {tc_q[ACW-1], tc_q[ACW-1:16]};
        mul_b = {17'b0, w_q};
      end
      vsb_pkg::MUL_TL: begin
        mul_a = {17'b0, tc_q[15:0]};
        mul_b = {17'b0, w_q};
      end
      default: begin
      end
    endcase
  end

  vsb_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_sel != vsb_pkg::MUL_NONE),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // transformed coordinate clamp to the accumulator range
  logic                  t_ovf;
  logic signed [ACW-1:0] t_sat;

  assign t_ovf = !((t_q[TW-1:ACW-1] == '0) || (t_q[TW-1:ACW-1] == '1));
  assign t_sat = t_ovf ? (t_q[TW-1] ? vsb_pkg::ACC_MIN : vsb_pkg::ACC_MAX)
                       : t_q[ACW-1:0];

  // weighted contribution added to the chosen accumulator, saturated
  logic signed [TW-1:0]  acc_sum;
  logic                  acc_ovf;
  logic signed [ACW-1:0] acc_sat;

  assign acc_sum = {{2{acc_q[ctrl.acc_idx][ACW-1]}}, acc_q[ctrl.acc_idx]} +
                   {wp_q[vsb_pkg::WP_W-1], wp_q[vsb_pkg::WP_W-1:15]};
  assign acc_ovf = !((acc_sum[TW-1:ACW-1] == '0) || (acc_sum[TW-1:ACW-1] == '1));
  assign acc_sat = acc_ovf ? (acc_sum[TW-1] ? vsb_pkg::ACC_MIN : vsb_pkg::ACC_MAX)
                           : acc_sum[ACW-1:0];

  // output clamp to q16.16
  logic [CW-1:0] oclamp [vsb_pkg::COORDS];
  logic [vsb_pkg::COORDS-1:0] oovf;

  always_comb begin
    for (int c = 0; c < vsb_pkg::COORDS; c++) begin
      oovf[c] = !((acc_q[c][ACW-1:CW-1] == '0) || (acc_q[c][ACW-1:CW-1] == '1));
      if (oovf[c]) begin
        oclamp[c] = acc_q[c][ACW-1] ? vsb_pkg::OUT_MIN : vsb_pkg::OUT_MAX;
      end else begin
        oclamp[c] = acc_q[c][CW-1:0];
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (is_infl) begin
      base_q <= vsb_pkg::pal_addr(in_joint[JW-2:0], '0);
      w_q    <= in_weight;
      vx_q   <= in_vx;
      vy_q   <= in_vy;
      vz_q   <= in_vz;
      last_q <= s_axis_tlast;
    end
  end

  // transform and weighting pipeline registers
  always_ff @(posedge clk_i) begin
    if (ctrl.t_init) begin
      t_q <= {{(TW-CW){rdata[CW-1]}}, rdata};
    end else if (ctrl.t_add) begin
      t_q <= t_q + prod[vsb_pkg::PROD_W-1:16];
    end
    if (ctrl.t_clamp) begin
      tc_q <= t_sat;
    end
    if (ctrl.wph_ld) begin
      wph_q <= prod[ACW-1:0];
    end
    if (ctrl.wp_ld) begin
      wp_q <= {wph_q, 16'b0} + {32'b0, prod[31:0]};
    end
  end

  // per-vertex state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      inf_cnt_q       <= '0;
      sat_q           <= 1'b0;
      for (int c = 0; c < vsb_pkg::COORDS; c++) begin
        acc_q[c] <= '0;
      end
    end else begin
      if (is_infl) begin
        first_pending_q <= 1'b0;
        if (cnt_ok) begin
          inf_cnt_q <= inf_cnt_q + 1'b1;
        end
      end
      if ((ctrl.t_clamp && t_ovf) || (ctrl.acc_ld && acc_ovf)) begin
        sat_q <= 1'b1;
      end
      if (ctrl.acc_ld) begin
        acc_q[ctrl.acc_idx] <= acc_sat;
      end
      if (out_load) begin
        first_pending_q <= 1'b1;
        inf_cnt_q       <= '0;
        sat_q           <= 1'b0;
        for (int c = 0; c < vsb_pkg::COORDS; c++) begin
          acc_q[c] <= '0;
        end
      end
    end
  end

  // control state machine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      osat_q    <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
        ox_q      <= oclamp[0];
        oy_q      <= oclamp[1];
        oz_q      <= oclamp[2];
        osat_q    <= sat_q || (oovf != '0);
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (counted) begin
            state_q <= S_RUN;
          end else if (is_infl && s_axis_tlast) begin
            state_q <= S_OUT;
          end
        end
        S_RUN: begin
          if (seq_stat.done) begin
            state_q <= last_q ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {oz_q, oy_q, ox_q};
  assign m_axis_tuser  = osat_q;

  // the sequencer only finishes while the block waits on it
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_stat.done |-> (state_q == S_RUN))
    else $error("sequencer finished outside of the run state");

  // the influence count never passes its limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(inf_cnt_q) <= vsb_pkg::MAX_INFLUENCES)
    else $error("influence count above limit");

  // emitting a vertex clears the per-vertex state
  a_clear_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0 &&
                  first_pending_q && !sat_q && inf_cnt_q == '0))
    else $error("per-vertex state not cleared after emit");

  // palette loads never overlap a running transform
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |-> !seq_stat.busy)
    else $error("palette write during sequencing");

endmodule

// ===== dv/vertex_skinning_blend_tb.sv =====
// testbench for vertex_skinning_blend: palette loads and skinned vertices checked against a blend predictor
`timescale 1ns / 1ps

module vertex_skinning_blend_tb;
  import vsb_pkg::*;

  typedef enum bit {
    OP_LOAD      = 1'b0,
    OP_INFLUENCE = 1'b1
  } op_e;

  // one input transfer, fields as the item defines them
  typedef struct packed {
    op_e                 op;
    logic [JOINT_W-1:0]  joint;
    logic [WORD_W-1:0]   element;
    logic [COORD_W-1:0]  value;
    logic [WEIGHT_W-1:0] weight;
    logic [COORD_W-1:0]  vx;
    logic [COORD_W-1:0]  vy;
    logic [COORD_W-1:0]  vz;
    logic                last;
  } item_t;

  // one blended vertex
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               sat;
  } blend_t;

  // directed row: the blend is typed in when fixed is set
  typedef struct packed {
    item_t  it;
    logic   fixed;
    blend_t want;
  } dir_row_t;

  localparam logic [COORD_W-1:0]  Q_ONE   = 32'h0001_0000;
  localparam logic [COORD_W-1:0]  Q_MAX   = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0]  Q_MIN   = 32'h8000_0000;
  localparam logic [COORD_W-1:0]  Q_ZERO  = 32'h0000_0000;
  localparam logic [COORD_W-1:0]  Q_ALL1  = 32'hFFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] W_ONE   = 16'h8000;
  localparam logic [WEIGHT_W-1:0] W_NONE  = 16'h0000;
  localparam logic [WEIGHT_W-1:0] W_FULL  = 16'hFFFF;

  localparam logic [JOINT_W-1:0] J_IDENT    = JOINT_W'(0);
  localparam logic [JOINT_W-1:0] J_LOW      = JOINT_W'(MAX_JOINTS - 2);
  localparam logic [JOINT_W-1:0] J_HIGH     = JOINT_W'(MAX_JOINTS - 1);
  localparam logic [JOINT_W-1:0] J_MOST_NEG = {1'b1, {(JOINT_W-1){1'b0}}};

  localparam logic [WORD_W-1:0] E_FIRST   = WORD_W'(0);
  localparam logic [WORD_W-1:0] E_TRANS_X = WORD_W'(ROW_TRANS * COLS);
  localparam logic [WORD_W-1:0] E_BAD     = WORD_W'(WORDS_PER_JOINT);
  localparam logic [WORD_W-1:0] E_TOP     = '1;

  localparam longint ACC_HI = longint'(ACC_MAX);
  localparam longint ACC_LO = longint'(ACC_MIN);
  localparam longint OUT_HI = longint'(OUT_MAX);
  localparam longint OUT_LO = longint'(OUT_MIN);

  localparam int PHASES         = 4;
  localparam int RAND_PER_PHASE = 190;
  localparam int WAIT_LIMIT     = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatch_cnt   = 0;

  // blends waiting for their output transfer, oldest first
  blend_t blend_due [$];

  // predictor state
  logic [COORD_W-1:0] pose_palette [PAL_DEPTH];
  longint             blend_acc [COORDS];
  bit                 first_open = 1'b1;
  int                 inf_seen   = 0;
  bit                 sat_flag   = 1'b0;

  // directed stimulus
  dir_row_t dir_tab [21] = '{
    // loads to bad addresses are dropped, their last flag too
    '{'{OP_LOAD, J_IDENT, E_BAD, Q_ALL1, W_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD, J_MOST_NEG, E_FIRST, Q_ALL1, W_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0},
      1'b0, '0},
    '{'{OP_LOAD, JOINT_UNUSED, E_TOP, Q_ALL1, W_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0},
      1'b0, '0},
    // identity joint passes the vertex through
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_ONE, 32'h0001_0000, 32'h0002_0000,
        32'h0003_0000, 1'b1}, 1'b1, '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0}},
    // first influence counts even at zero weight
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_NONE, 32'h0005_0000, 32'h0005_0000,
        32'h0005_0000, 1'b1}, 1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    // unused joint on the first influence gives nothing
    '{'{OP_INFLUENCE, JOINT_UNUSED, E_FIRST, Q_ZERO, W_ONE, Q_MAX, Q_MAX, Q_MAX, 1'b1},
      1'b1, '{Q_ZERO, Q_ZERO, Q_ZERO, 1'b0}},
    // saturation at both ends
    '{'{OP_INFLUENCE, J_HIGH, E_FIRST, Q_ZERO, W_ONE, Q_MAX, Q_MAX, Q_MAX, 1'b1},
      1'b1, '{Q_MAX, Q_MAX, Q_MAX, 1'b1}},
    '{'{OP_INFLUENCE, J_LOW, E_FIRST, Q_ZERO, W_ONE, Q_MAX, Q_MAX, Q_MAX, 1'b1},
      1'b1, '{Q_MIN, Q_MIN, Q_MIN, 1'b1}},
    // most negative vertex fits without a clamp
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_ONE, Q_MIN, Q_MIN, Q_MIN, 1'b1},
      1'b1, '{Q_MIN, Q_MIN, Q_MIN, 1'b0}},
    // weight above one
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_FULL, Q_ONE, Q_ONE, Q_ONE, 1'b1},
      1'b0, '0},
    // five influences: skipped ones still count, the fifth is dropped but emits
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, 16'h4000, 32'h0004_0000, 32'hFFFD_0000,
        32'h0002_0000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, JOINT_W'(5), E_FIRST, Q_ZERO, 16'h2000, 32'h0004_0000, 32'hFFFD_0000,
        32'h0002_0000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_NONE, 32'h0004_0000, 32'hFFFD_0000,
        32'h0002_0000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, JOINT_UNUSED, E_FIRST, Q_ZERO, W_ONE, 32'h0004_0000, 32'hFFFD_0000,
        32'h0002_0000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, JOINT_W'(1), E_FIRST, Q_ZERO, W_ONE, 32'h0004_0000, 32'hFFFD_0000,
        32'h0002_0000, 1'b1}, 1'b0, '0},
    // a negative joint other than unused counts but adds nothing
    '{'{OP_INFLUENCE, JOINT_W'(3), E_FIRST, Q_ZERO, 16'd20000, 32'h0001_8000, 32'hFFFF_4000,
        32'h0000_2000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, J_MOST_NEG, E_FIRST, Q_ZERO, 16'd100, 32'h0001_8000, 32'hFFFF_4000,
        32'h0000_2000, 1'b0}, 1'b0, '0},
    '{'{OP_INFLUENCE, JOINT_W'(2), E_FIRST, Q_ZERO, 16'd30000, 32'h0001_8000, 32'hFFFF_4000,
        32'h0000_2000, 1'b1}, 1'b0, '0},
    // translation row alone, then restored
    '{'{OP_LOAD, J_IDENT, E_TRANS_X, 32'h0010_0000, W_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0},
      1'b0, '0},
    '{'{OP_INFLUENCE, J_IDENT, E_FIRST, Q_ZERO, W_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1},
      1'b1, '{32'h0010_0000, Q_ZERO, Q_ZERO, 1'b0}},
    '{'{OP_LOAD, J_IDENT, E_TRANS_X, Q_ZERO, W_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0},
      1'b0, '0}
  };

  vertex_skinning_blend u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // clamp with the sticky saturation flag
  function automatic longint sat_clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      sat_flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint pal_word(int j, int e);
    return longint'($signed(pose_palette[j * WORDS_PER_JOINT + e]));
  endfunction

  // blend predictor: one accepted item in, at most one blended vertex out
  task automatic blend_step(input item_t it, output bit emit, output blend_t res);
    int     j;
    longint vtx [COORDS];
    longint t;
    longint o [COORDS];
    emit = 1'b0;
    res  = '0;
    j    = int'($signed(it.joint));
    if (it.op == OP_LOAD) begin
      if (j >= 0 && j < MAX_JOINTS && int'(it.element) < WORDS_PER_JOINT)
        pose_palette[j * WORDS_PER_JOINT + int'(it.element)] = it.value;
      return;
    end
    vtx[0] = longint'($signed(it.vx));
    vtx[1] = longint'($signed(it.vy));
    vtx[2] = longint'($signed(it.vz));
    // counted influence: row-vector transform, weight, accumulate
    if (inf_seen < MAX_INFLUENCES) begin
      if (first_open || (it.weight != W_NONE && it.joint != JOINT_UNUSED)) begin
        if (j >= 0 && j < MAX_JOINTS) begin
          for (int c = 0; c < COORDS; c++) begin
            t = pal_word(j, ROW_TRANS * COLS + c);
            for (int r = 0; r < ROW_TRANS; r++)
              t += (vtx[r] * pal_word(j, r * COLS + c)) >>> 16;
            t = sat_clamp(t, ACC_LO, ACC_HI);
            t = (t * longint'(it.weight)) >>> 15;
            blend_acc[c] = sat_clamp(blend_acc[c] + t, ACC_LO, ACC_HI);
          end
        end
      end
      inf_seen++;
    end
    first_open = 1'b0;
    if (!it.last)
      return;
    // emit and open the next vertex
    for (int c = 0; c < COORDS; c++)
      o[c] = sat_clamp(blend_acc[c], OUT_LO, OUT_HI);
    res.x   = o[0][COORD_W-1:0];
    res.y   = o[1][COORD_W-1:0];
    res.z   = o[2][COORD_W-1:0];
    res.sat = sat_flag;
    emit    = 1'b1;
    for (int c = 0; c < COORDS; c++)
      blend_acc[c] = 0;
    first_open = 1'b1;
    inf_seen   = 0;
    sat_flag   = 1'b0;
  endtask

  // mostly modest Q16.16 values, with full-range words and extremes mixed in
  function automatic logic [COORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5, 6: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      7: return $urandom();
      8: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ZERO;
          default: return Q_ALL1;
        endcase
      end
      default: return ($urandom_range(0, 8) - 4) << 16;
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return WEIGHT_W'($urandom_range(0, 32768));
      5: return W_NONE;
      6: return W_ONE;
      7: return WEIGHT_W'($urandom());
      8: return WEIGHT_W'($urandom_range(1, 255));
      default: return 16'h4000;
    endcase
  endfunction

  // later influences see the unused marker and other negatives more often
  function automatic logic [JOINT_W-1:0] pick_joint(bit first);
    int r;
    r = int'($urandom_range(0, 99));
    if (r < (first ? 90 : 70))
      return JOINT_W'($urandom_range(0, MAX_JOINTS - 1));
    if (r < (first ? 95 : 85))
      return JOINT_UNUSED;
    return JOINT_W'($urandom_range(64, 126));
  endfunction

  // a load carries noise in the fields it ignores
  function automatic item_t load_item(logic [JOINT_W-1:0] j, logic [WORD_W-1:0] e,
                                      logic [COORD_W-1:0] val);
    item_t it;
    it.op      = OP_LOAD;
    it.joint   = j;
    it.element = e;
    it.value   = val;
    it.weight  = rand_weight();
    it.vx      = $urandom();
    it.vy      = $urandom();
    it.vz      = $urandom();
    it.last    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // drive one item, wait for its transfer, then predict it
  task automatic push_item(input item_t it, input bit fixed, input blend_t want);
    bit     emit;
    blend_t pred;
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {5'd0, it.vz, it.vy, it.vx, it.weight, it.value, it.element, it.joint};
    do @(posedge clk_i); while (!s_axis_tready);
    blend_step(it, emit, pred);
    if (fixed)
      blend_due.push_back(want);
    else if (emit)
      blend_due.push_back(pred);
  endtask

  // output side stalls
  always @(posedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
  end

  // compare each output transfer with the oldest expected blend
  always @(posedge clk_i) begin : check_blend
    blend_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blend_due.size() == 0) begin
        report_mismatch($sformatf("blend %h sat %b with none expected", m_axis_tdata,
                                  m_axis_tuser));
      end else begin
        want = blend_due.pop_front();
        if (m_axis_tdata[31:0] !== want.x)
          report_mismatch($sformatf("out_x %h, expected %h", m_axis_tdata[31:0], want.x));
        if (m_axis_tdata[63:32] !== want.y)
          report_mismatch($sformatf("out_y %h, expected %h", m_axis_tdata[63:32], want.y));
        if (m_axis_tdata[95:64] !== want.z)
          report_mismatch($sformatf("out_z %h, expected %h", m_axis_tdata[95:64], want.z));
        if (m_axis_tuser !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b", m_axis_tuser, want.sat));
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("vertex_skinning_blend_tb: done, errors");
    $finish;
  end

  initial begin
    item_t              it;
    logic [COORD_W-1:0] word;
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    int                 n_inf;
    int                 n_len;
    int                 pick;
    int                 k;
    for (int c = 0; c < COORDS; c++)
      blend_acc[c] = 0;
    foreach (pose_palette[i])
      pose_palette[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole palette: identity, all-max and all-min joints, the rest random
    for (int j = 0; j < MAX_JOINTS; j++) begin
      for (int e = 0; e < WORDS_PER_JOINT; e++) begin
        if (JOINT_W'(j) == J_IDENT)
          word = (e / COLS == e % COLS) ? Q_ONE : Q_ZERO;
        else if (JOINT_W'(j) == J_HIGH)
          word = Q_MAX;
        else if (JOINT_W'(j) == J_LOW)
          word = Q_MIN;
        else
          word = rand_word();
        push_item(load_item(JOINT_W'(j), WORD_W'(e), word), 1'b0, '0);
      end
    end

    // directed rows
    foreach (dir_tab[i])
      push_item(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].want);

    // random vertices with reloads and dropped loads in between
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 45;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 45;
        end
        default: begin
          src_idle_pct   = 23;
          sink_stall_pct = 23;
        end
      endcase
      n_inf = 0;
      while (n_inf < RAND_PER_PHASE) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 12) begin
          push_item(load_item(JOINT_W'($urandom_range(0, MAX_JOINTS - 1)),
                              WORD_W'($urandom_range(0, WORDS_PER_JOINT - 1)), rand_word()),
                    1'b0, '0);
        end else if (pick < 15) begin
          if ($urandom_range(0, 1) == 0)
            it = load_item(JOINT_W'($urandom_range(64, 127)), WORD_W'($urandom()), $urandom());
          else
            it = load_item(JOINT_W'($urandom_range(0, MAX_JOINTS - 1)),
                           WORD_W'($urandom_range(WORDS_PER_JOINT, 15)), $urandom());
          push_item(it, 1'b0, '0);
        end else begin
          // one vertex, sometimes with more influences than the block keeps
          if ($urandom_range(0, 4) == 0)
            n_len = int'($urandom_range(MAX_INFLUENCES + 1, MAX_INFLUENCES + 3));
          else
            n_len = int'($urandom_range(1, MAX_INFLUENCES));
          vx = rand_word();
          vy = rand_word();
          vz = rand_word();
          for (k = 0; k < n_len; k++) begin
            it.op      = OP_INFLUENCE;
            it.joint   = pick_joint(k == 0);
            it.element = WORD_W'($urandom());
            it.value   = $urandom();
            it.weight  = rand_weight();
            if ($urandom_range(0, 9) == 0) begin
              it.vx = rand_word();
              it.vy = rand_word();
              it.vz = rand_word();
            end else begin
              it.vx = vx;
              it.vy = vy;
              it.vz = vz;
            end
            it.last = (k == n_len - 1);
            push_item(it, 1'b0, '0);
            n_inf++;
          end
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding blends, then let the pipeline settle
    for (k = 0; k < WAIT_LIMIT && blend_due.size() != 0; k++)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (blend_due.size() != 0)
      report_mismatch($sformatf("%0d blended vertices never arrived", blend_due.size()));

    if (mismatch_cnt == 0)
      $display("vertex_skinning_blend_tb: done, clean");
    else
      $display("vertex_skinning_blend_tb: done, errors");
    $finish;
  end

endmodule
